// ----- rtl/cluster_chain_table_engine_top_defines.svh -----
// Assertion macros shared by the cluster table RTL.
`ifndef CLUSTER_CHAIN_TABLE_ENGINE_TOP_DEFINES_SVH
`define CLUSTER_CHAIN_TABLE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CCE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cluster table check failed");

// Next-cycle implication, checked out of reset.
`define CCE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cluster table check failed");

`endif

// ----- rtl/cce_pkg.sv -----
// Shared constants, codes and the table port request type.
`timescale 1ns / 1ps
`default_nettype none

package cce_pkg;

	localparam int CLUSTER_W = 16;

	localparam logic [15:0] ENTRY_FREE = 16'h0000;
	localparam logic [15:0] CHAIN_END  = 16'hFFF8;
	localparam logic [15:0] ALLOC_MARK = 16'hFFFF;
	localparam logic [15:0] FIRST_DATA = 16'h0002;

	localparam logic [2:0] OP_READ  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_FIND  = 3'd2;
	localparam logic [2:0] OP_ALLOC = 3'd3;
	localparam logic [2:0] OP_FREE  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFREE  = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_TOOLONG = 2'd3;

	// one read and one write port, addresses at full cluster width
	typedef struct packed {
		logic                 re;
		logic [CLUSTER_W-1:0] raddr;
		logic                 we;
		logic [CLUSTER_W-1:0] waddr;
		logic [CLUSTER_W-1:0] wdata;
	} ram_req_t;

	function automatic logic is_link(input logic [15:0] c);
		is_link = (c >= FIRST_DATA) && (c < CHAIN_END);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/cce_table_ram.sv -----
// Cluster table storage: one write port, one registered read port, write-first.
`timescale 1ns / 1ps
`default_nettype none

module cce_table_ram #(
	parameter int DEPTH = 65536
) (
	input  wire logic              clk,
	input  wire cce_pkg::ram_req_t req,
	output logic [15:0]            rdata
);
	import cce_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			// a read of the entry being written sees the new value
			if (req.we && (req.waddr[AW-1:0] == req.raddr[AW-1:0])) begin
				rdata_q <= req.wdata;
			end else begin
				rdata_q <= mem[req.raddr[AW-1:0]];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/cce_engine.sv -----
// Operation sequencer: read, write, free scan, allocate and chain free, plus result register.
`timescale 1ns / 1ps
`default_nettype none
`include "cluster_chain_table_engine_top_defines.svh"

module cce_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clr_busy,
	input  wire logic [16:0]       lim,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        op,
	input  wire logic [15:0]       cluster,
	input  wire logic [15:0]       value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [15:0]            result_value,
	output logic [1:0]             status,
	output cce_pkg::ram_req_t      req,
	input  wire logic [15:0]       rdata
);
	import cce_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]  state_q, state_d;
	logic [2:0]  op_q;
	logic [16:0] lim_q;
	logic [15:0] scan_q, scan_d;
	logic [15:0] cur_q, cur_d;
	logic [16:0] count_q, count_d, count_n;
	logic [15:0] res_q;
	logic [1:0]  st_q;
	logic        out_valid_q;
	logic [15:0] out_res_q;
	logic [1:0]  out_st_q;

	logic        accept, cl_ok, slot_free;
	logic        fin_valid;
	logic [15:0] fin_res;
	logic [1:0]  fin_st;
	logic        scan_in_range, cur_in_range, rd_accept;

	function automatic logic [15:0] sat16(input logic [16:0] c);
		sat16 = c[16] ? 16'hFFFF : c[15:0];
	endfunction

	assign in_ready  = (state_q == S_IDLE) && !clr_busy;
	assign accept    = in_valid && in_ready;
	assign cl_ok     = {1'b0, cluster} < lim;
	assign slot_free = !out_valid_q || out_ready;
	assign count_n   = count_q + 17'd1;

	always_comb begin
		req       = '0;
		fin_valid = 1'b0;
		fin_res   = ENTRY_FREE;
		fin_st    = ST_OK;
		state_d   = state_q;
		scan_d    = scan_q;
		cur_d     = cur_q;
		count_d   = count_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_READ: begin
							if (cl_ok) begin
								req.re    = 1'b1;
								req.raddr = cluster;
								state_d   = S_RD;
							end else begin
								fin_valid = 1'b1;
								fin_st    = ST_RANGE;
							end
						end
						OP_WRITE: begin
							fin_valid = 1'b1;
							if (cl_ok) begin
								req.we    = 1'b1;
								req.waddr = cluster;
								req.wdata = value;
							end else begin
								fin_st = ST_RANGE;
							end
						end
						OP_FIND, OP_ALLOC: begin
							if (lim <= 17'd2) begin
								fin_valid = 1'b1;
								fin_res   = ALLOC_MARK;
								fin_st    = ST_NOFREE;
							end else begin
								req.re    = 1'b1;
								req.raddr = FIRST_DATA;
								scan_d    = FIRST_DATA;
								state_d   = S_SCAN;
							end
						end
						OP_FREE: begin
							if (!is_link(cluster)) begin
								fin_valid = 1'b1;
							end else if (!cl_ok) begin
								fin_valid = 1'b1;
								fin_st    = ST_RANGE;
							end else begin
								req.re    = 1'b1;
								req.raddr = cluster;
								cur_d     = cluster;
								count_d   = '0;
								state_d   = S_WALK;
							end
						end
						default: begin
							fin_valid = 1'b1;
						end
					endcase
				end
			end
			S_RD: begin
				fin_valid = 1'b1;
				fin_res   = rdata;
			end
			S_SCAN: begin
				// rdata holds the entry at scan_q; the next entry is fetched meanwhile
				if (rdata == ENTRY_FREE) begin
					fin_valid = 1'b1;
					if (scan_q == ALLOC_MARK) begin
						// last cluster number collides with the none-found code
						fin_res = ALLOC_MARK;
						fin_st  = ST_NOFREE;
					end else begin
						fin_res = scan_q;
						if (op_q == OP_ALLOC) begin
							req.we    = 1'b1;
							req.waddr = scan_q;
							req.wdata = ALLOC_MARK;
						end
					end
				end else if (({1'b0, scan_q} + 17'd1) >= lim_q) begin
					fin_valid = 1'b1;
					fin_res   = ALLOC_MARK;
					fin_st    = ST_NOFREE;
				end else begin
					req.re    = 1'b1;
					req.raddr = scan_q + 16'd1;
					scan_d    = scan_q + 16'd1;
				end
			end
			S_WALK: begin
				// free the visited entry while fetching its link target
				req.we    = 1'b1;
				req.waddr = cur_q;
				req.wdata = ENTRY_FREE;
				fin_res   = sat16(count_n);
				if (!is_link(rdata)) begin
					fin_valid = 1'b1;
				end else if ({1'b0, rdata} >= lim_q) begin
					fin_valid = 1'b1;
					fin_st    = ST_RANGE;
				end else if (count_n >= lim_q) begin
					fin_valid = 1'b1;
					fin_st    = ST_TOOLONG;
				end else begin
					req.re    = 1'b1;
					req.raddr = rdata;
					cur_d     = rdata;
					count_d   = count_n;
				end
			end
			S_DONE: begin
				fin_valid = 1'b1;
				fin_res   = res_q;
				fin_st    = st_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin_valid) begin
			state_d = slot_free ? S_IDLE : S_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_valid && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			lim_q <= lim;
		end
		scan_q  <= scan_d;
		cur_q   <= cur_d;
		count_q <= count_d;
		if (fin_valid && !slot_free) begin
			res_q <= fin_res;
			st_q  <= fin_st;
		end
		if (fin_valid && slot_free) begin
			out_res_q <= fin_res;
			out_st_q  <= fin_st;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign status       = out_st_q;

	assign scan_in_range = {1'b0, scan_q} < lim_q;
	assign cur_in_range  = {1'b0, cur_q} < lim_q;
	assign rd_accept     = accept && (op == OP_READ) && cl_ok;

	`CCE_ASSERT_IMP(a_scan_in_range, state_q == S_SCAN, scan_in_range)
	`CCE_ASSERT_IMP(a_walk_in_range, state_q == S_WALK, cur_in_range)
	`CCE_ASSERT_NXT(a_read_waits_data, rd_accept, state_q == S_RD)

endmodule

`default_nettype wire

// ----- rtl/cluster_chain_table_engine_top.sv -----
// Top level: entry count register, clearing pass after reset, table and sequencer.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+---------------------------------
//  in       | in_valid/in_ready                | request: op, cluster, value
//  out      | out_valid/out_ready              | result_value, status
//  cfg      | cfg_we, cfg_wdata                | entry_count write, no wait
//
// A read answers from the registered table read, a write finishes on acceptance,
// find/allocate scan entries and free walks the chain; the table's single read
// port fetches one entry a cycle. After reset a clearing pass zeroes the table
// with in_ready low; config writes are taken meanwhile.
// A held result does not block acceptance; the next result waits for the slot.
`timescale 1ns / 1ps
`default_nettype none
`include "cluster_chain_table_engine_top_defines.svh"

module cluster_chain_table_engine_top #(
	parameter int TABLE_ENTRIES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  op,
	input  wire logic [15:0] cluster,
	input  wire logic [15:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      result_value,
	output logic [1:0]       status
);
	import cce_pkg::*;

	localparam int          AW        = $clog2(TABLE_ENTRIES);
	localparam logic [16:0] TABLE_LIM = 17'(TABLE_ENTRIES);
	localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_ENTRIES - 1);

	logic [16:0]   entry_count_q;
	logic [16:0]   lim;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	ram_req_t      eng_req, ram_req;
	logic [15:0]   rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= 17'h10000;
			clr_busy_q    <= 1'b1;
			clr_addr_q    <= '0;
		end else begin
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	assign lim = (entry_count_q > TABLE_LIM) ? TABLE_LIM : entry_count_q;

	always_comb begin
		ram_req = eng_req;
		if (clr_busy_q) begin
			ram_req       = '0;
			ram_req.we    = 1'b1;
			ram_req.waddr = CLUSTER_W'(clr_addr_q);
			ram_req.wdata = ENTRY_FREE;
		end
	end

	cce_table_ram #(
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rdata(rdata)
	);

	cce_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr_busy    (clr_busy_q),
		.lim         (lim),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.cluster     (cluster),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value),
		.status      (status),
		.req         (eng_req),
		.rdata       (rdata)
	);

	`CCE_ASSERT_IMP(a_no_accept_while_clearing, clr_busy_q, !in_ready)

endmodule

`default_nettype wire

// ----- dv/tb_cluster_chain_table_engine_top.sv -----
// Self-checking testbench for the cluster chain table engine: directed and random requests.
`timescale 1ns / 1ps

module tb_cluster_chain_table_engine_top;
	import cce_pkg::*;

	localparam int         FULL_TABLE    = 65536;
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
	localparam int         RANDOM_ITEMS  = 1925;
	localparam int         SIZE_PHASES   = 10;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         MAX_REPORTS   = 10;

	// receiver stall modes
	localparam int RX_OPEN  = 0;
	localparam int RX_COIN  = 1;
	localparam int RX_TIGHT = 2;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] cluster;
		logic [15:0] result_value;
		logic [1:0]  status;
	} outcome_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [2:0]  op        = '0;
	logic [15:0] cluster   = '0;
	logic [15:0] value     = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] result_value;
	logic [1:0]  status;

	logic [15:0] shadow_fat [0:FULL_TABLE-1];
	logic [16:0] shadow_entry_count;
	outcome_t    pending_outcomes [$];
	int          mismatch_count = 0;
	int          burst_left     = 0;
	int          rx_mode        = RX_OPEN;
	int          rx_span        = 0;

	cluster_chain_table_engine_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.cluster      (cluster),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// the clearing pass after reset covers the full table; the rest is bounded by small tables
	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned current_limit();
		return (shadow_entry_count > FULL_TABLE) ? FULL_TABLE : shadow_entry_count;
	endfunction

	// Applies one request to the shadow table and returns what the block should answer.
	function automatic outcome_t table_apply(input logic [2:0] opc, input logic [15:0] cl,
			input logic [15:0] val);
		outcome_t    o;
		int unsigned lim;
		int unsigned cur;
		int unsigned nxt;
		int unsigned freed;
		int unsigned c;
		o.op           = opc;
		o.cluster      = cl;
		o.result_value = '0;
		o.status       = ST_OK;
		lim            = current_limit();
		case (opc)
			OP_READ: begin
				if (cl < lim) o.result_value = shadow_fat[cl];
				else o.status = ST_RANGE;
			end
			OP_WRITE: begin
				if (cl < lim) shadow_fat[cl] = val;
				else o.status = ST_RANGE;
			end
			OP_FIND, OP_ALLOC: begin
				o.result_value = ALLOC_MARK;
				o.status       = ST_NOFREE;
				for (c = FIRST_DATA; c < lim; c++) begin
					if (shadow_fat[c] == ENTRY_FREE) begin
						// the last cluster number reads as none found
						if (c != ALLOC_MARK) begin
							o.result_value = c[15:0];
							o.status       = ST_OK;
							if (opc == OP_ALLOC) shadow_fat[c] = ALLOC_MARK;
						end
						break;
					end
				end
			end
			OP_FREE: begin
				cur   = cl;
				freed = 0;
				while (cur >= FIRST_DATA && cur < CHAIN_END) begin
					if (cur >= lim) begin
						o.status = ST_RANGE;
						break;
					end
					if (freed >= lim) begin
						o.status = ST_TOOLONG;
						break;
					end
					nxt             = shadow_fat[cur];
					shadow_fat[cur] = ENTRY_FREE;
					freed++;
					cur             = nxt;
				end
				// count saturates at 16 bits
				o.result_value = (freed > 16'hFFFF) ? 16'hFFFF : freed[15:0];
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic logic [15:0] pick_cluster(input int unsigned lim);
		int unsigned sel;
		int unsigned c;
		sel = $urandom_range(0, 99);
		if (sel < 70) c = $urandom_range(0, lim - 1);
		else if (sel < 85) c = lim + $urandom_range(0, 3);
		else if (sel < 92) c = $urandom_range(CHAIN_END - 2, ALLOC_MARK);
		else c = $urandom_range(0, 16'hFFFF);
		if (c > 16'hFFFF) c = 16'hFFFF;
		return c[15:0];
	endfunction

	function automatic logic [15:0] pick_value(input int unsigned lim);
		int unsigned sel;
		int unsigned v;
		sel = $urandom_range(0, 99);
		if (sel < 35 && lim > FIRST_DATA) v = $urandom_range(FIRST_DATA, lim - 1);
		else if (sel < 50) v = ENTRY_FREE;
		else if (sel < 65) v = $urandom_range(CHAIN_END, ALLOC_MARK);
		else if (sel < 72) v = $urandom_range(0, FIRST_DATA - 1);
		else v = $urandom_range(0, 16'hFFFF);
		return v[15:0];
	endfunction

	// Sends one request and books its expected answer once it is taken.
	task automatic send_request(input logic [2:0] opc, input logic [15:0] cl,
			input logic [15:0] val);
		in_valid <= 1'b1;
		op       <= opc;
		cluster  <= cl;
		value    <= val;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_outcomes.push_back(table_apply(opc, cl, val));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// Holds off new requests until every answer is back and the block is idle.
	task automatic wait_results();
		if (in_valid) in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_entry_count(input logic [16:0] n);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_entry_count = n;
	endtask

	task automatic send_single(input int unsigned lim);
		int unsigned sel;
		logic [2:0]  opc;
		sel = $urandom_range(0, 99);
		if (sel < 20) opc = OP_READ;
		else if (sel < 42) opc = OP_WRITE;
		else if (sel < 52) opc = OP_FIND;
		else if (sel < 70) opc = OP_ALLOC;
		else if (sel < 94) opc = OP_FREE;
		else opc = $urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST);
		send_request(opc, pick_cluster(lim), pick_value(lim));
	endtask

	// Links a few in-range clusters into a chain, then frees it from its head.
	task automatic send_chain(input int unsigned lim, inout int sent);
		logic [15:0] links [0:7];
		logic [15:0] tail;
		int          len;
		int          i;
		len = $urandom_range(1, 8);
		for (i = 0; i < len; i++) links[i] = $urandom_range(FIRST_DATA, lim - 1);
		for (i = 0; i < len; i++) begin
			if (i < len - 1) begin
				tail = links[i + 1];
			end else begin
				case ($urandom_range(0, 5))
					0: tail = pick_value(lim);
					1: tail = (lim < CHAIN_END) ? $urandom_range(lim, CHAIN_END - 1)
						: $urandom_range(CHAIN_END, ALLOC_MARK);
					default: tail = $urandom_range(CHAIN_END, ALLOC_MARK);
				endcase
			end
			send_request(OP_WRITE, links[i], tail);
			sent++;
		end
		if ($urandom_range(0, 1) == 1) begin
			send_request(OP_READ, links[0], $urandom_range(0, 16'hFFFF));
			sent++;
		end
		send_request(OP_FREE, links[0], $urandom_range(0, 16'hFFFF));
		sent++;
	endtask

	// Full-size table straight after reset: extremes, scans, a looped chain, bad starts.
	task automatic test_full_table();
		int k;
		send_request(OP_READ, 16'h0000, 16'h0000);
		send_request(OP_READ, 16'hFFFF, 16'hFFFF);
		send_request(OP_WRITE, 16'hFFFF, ALLOC_MARK);
		send_request(OP_READ, 16'hFFFF, 16'h0000);
		send_request(OP_FIND, 16'h0000, 16'h0000);
		send_request(OP_ALLOC, 16'hFFFF, 16'hFFFF);
		send_request(OP_FIND, 16'h0000, 16'h0000);
		// 3 -> 5 -> 3: the revisit reads free and ends the walk
		send_request(OP_WRITE, 16'h0003, 16'h0005);
		send_request(OP_WRITE, 16'h0005, 16'h0003);
		send_request(OP_FREE, 16'h0003, 16'h0000);
		send_request(OP_FREE, 16'h0001, 16'hFFFF);
		send_request(OP_FREE, CHAIN_END, 16'h0000);
		send_request(OP_FREE, 16'hFFFF, 16'h0000);
		for (k = OP_RSVD_FIRST; k <= OP_RSVD_LAST; k++)
			send_request(k, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
		wait_results();
	endtask

	// Tiny tables: range errors, table full, chains leaving the table.
	task automatic test_small_table();
		write_entry_count(17'd3);
		send_request(OP_READ, 16'h0003, 16'h0000);
		send_request(OP_WRITE, 16'hFFFF, 16'h1234);
		send_request(OP_WRITE, FIRST_DATA, ENTRY_FREE);
		send_request(OP_ALLOC, 16'h0000, 16'h0000);
		send_request(OP_ALLOC, 16'h0000, 16'h0000);
		send_request(OP_FREE, FIRST_DATA, 16'h0000);
		send_request(OP_WRITE, FIRST_DATA, 16'h0007);
		send_request(OP_FREE, FIRST_DATA, 16'h0000);
		send_request(OP_FREE, 16'h0005, 16'h0000);
		wait_results();
		write_entry_count(17'd2);
		send_request(OP_FIND, 16'h0000, 16'h0000);
		send_request(OP_ALLOC, 16'h0000, 16'h0000);
		send_request(OP_READ, 16'h0001, 16'h0000);
		wait_results();
	endtask

	// Random traffic over a series of table sizes, mostly well-formed chains.
	task automatic test_random_traffic();
		logic [16:0] sizes [0:SIZE_PHASES-1];
		int unsigned lim;
		int          sent;
		int          p;
		sizes = '{17'd9, 17'd24, 17'd2, 17'd64, 17'd200, 17'd3, 17'd256, 17'd65535,
			17'd37, 17'h10000};
		for (p = 0; p < SIZE_PHASES; p++) begin
			write_entry_count(sizes[p]);
			lim  = current_limit();
			sent = 0;
			while (sent < RANDOM_ITEMS / SIZE_PHASES) begin
				if (lim > FIRST_DATA && $urandom_range(0, 99) < 55) begin
					send_chain(lim, sent);
				end else begin
					send_single(lim);
					sent++;
				end
				if ($urandom_range(0, 149) == 0) wait_results();
			end
			wait_results();
		end
	endtask

	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_mode <= $urandom_range(RX_OPEN, RX_TIGHT);
			rx_span <= $urandom_range(16, 400);
		end else begin
			rx_span <= rx_span - 1;
		end
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: answer with no request pending: value %h status %0d",
						$time, result_value, status);
			end else begin
				want = pending_outcomes.pop_front();
				if (result_value !== want.result_value || status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: op %0d cluster %h: expected %h/%0d, got %h/%0d",
							$time, want.op, want.cluster, want.result_value,
							want.status, result_value, status);
				end
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < FULL_TABLE; i++) shadow_fat[i] = ENTRY_FREE;
		shadow_entry_count = 17'h10000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// taken during the clearing pass
		write_entry_count(FULL_TABLE);
		test_full_table();
		test_small_table();
		test_random_traffic();
		wait_results();
		repeat (32) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cce_pkg.sv
rtl/cce_table_ram.sv
rtl/cce_engine.sv
rtl/cluster_chain_table_engine_top.sv
dv/tb_cluster_chain_table_engine_top.sv
